// ----- sv/cfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants and types for the checksummed frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 260;
    localparam int unsigned FRAME_OVERHEAD  = 4;
    localparam logic [8:0]  MAX_DATA_LEN    = 9'(MAX_FRAME_BYTES - FRAME_OVERHEAD);

    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_ETB = 8'h17;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FORMAT   = 2'd1;
    localparam logic [1:0] ST_LENGTH   = 2'd2;
    localparam logic [1:0] ST_CHECKSUM = 2'd3;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_DATA   = 3'd2;
    localparam logic [2:0] PH_CHECK  = 3'd3;
    localparam logic [2:0] PH_FOOTER = 3'd4;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] start_byte;
        logic [8:0] data_length;
        logic [8:0] bytes_seen;
        logic [7:0] running_sum;
        logic [7:0] checksum_byte;
    } cfr_state_t;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [1:0] status;
        logic [8:0] frame_length;
        logic       last;
    } cfr_result_t;

endpackage
`default_nettype wire

// ----- sv/checksummed_frame_receiver_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_unit
// Deframes STX / length / data / checksum / ETB-ETX response frames.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_axis   in   tdata: rx_byte, expected_length
//  m_axis   out  tdata: data_byte, byte_index, status, frame_length;
//                tuser: result_kind; tlast: last
//
//  One byte per cycle; a result appears in the output register the cycle
//  after its byte is taken. Frame state updates in the same cycle.
//  Reset returns the decoder to waiting for the start byte, output empty.
//  A full output register stalls the input only while m_axis_tready is low.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // rx_byte[7:0], expected_length[16:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // data_byte[7:0], byte_index[15:8],
                                        // status[17:16], frame_length[26:18]
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // last
);
    import cfr_pkg::*;

    cfr_state_t  state_reg;
    cfr_state_t  state_next;
    cfr_result_t result;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_data_reg;
    logic        out_kind_reg;
    logic        out_last_reg;
    logic        s_take;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    cfr_step u_step (
        .state           (state_reg),
        .rx_byte         (s_axis_tdata[7:0]),
        .expected_length (s_axis_tdata[16:8]),
        .state_next      (state_next),
        .result          (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (s_take && result.valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s_take)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take && result.valid)
        begin
            out_data_reg <= {5'd0, result.frame_length, result.status,
                             result.byte_index, result.data_byte};
            out_kind_reg <= result.kind;
            out_last_reg <= result.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // status transactions carry tlast, data transactions do not
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("tlast does not match result kind");

    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_DATA) |-> (m_axis_tdata[17:16] == ST_OK))
        else $error("data transaction with nonzero status");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_DATA)
            |-> ({1'b0, m_axis_tdata[15:8]} < m_axis_tdata[26:18]))
        else $error("byte index beyond frame length");

    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_take && state_reg.phase == PH_START && !(out_valid_reg && !m_axis_tready))
            |=> !m_axis_tvalid)
        else $error("result produced for a start byte");

endmodule
`default_nettype wire

// ----- sv/cfr_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_step
// Per-byte decode: next frame state and the optional result for one byte.
// ----------------------------------------------------------------------------
module cfr_step (
    input  cfr_pkg::cfr_state_t  state,
    input  logic [7:0]           rx_byte,
    input  logic [8:0]           expected_length,
    output cfr_pkg::cfr_state_t  state_next,
    output cfr_pkg::cfr_result_t result
);
    import cfr_pkg::*;

    logic [8:0] dlen;
    logic [8:0] seen_inc;
    logic [7:0] check_sum;

    assign dlen      = (rx_byte == 8'd0) ? 9'd256 : {1'b0, rx_byte};
    assign seen_inc  = state.bytes_seen + 9'd1;
    assign check_sum = state.running_sum + state.checksum_byte;

    always_comb
    begin
        state_next          = state;
        result              = '0;
        result.frame_length = state.data_length;
        unique case (state.phase)
            PH_START:
            begin
                state_next.start_byte = rx_byte;
                state_next.phase      = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                state_next.data_length = dlen;
                result.frame_length    = dlen;
                result.kind            = KIND_STATUS;
                result.last            = 1'b1;
                priority if (state.start_byte != BYTE_STX || dlen > MAX_DATA_LEN)
                begin
                    state_next.phase = PH_START;
                    result.valid     = 1'b1;
                    result.status    = ST_FORMAT;
                end
                else if (expected_length != dlen)
                begin
                    state_next.phase = PH_START;
                    result.valid     = 1'b1;
                    result.status    = ST_LENGTH;
                end
                else
                begin
                    state_next.running_sum = rx_byte;
                    state_next.bytes_seen  = 9'd0;
                    state_next.phase       = PH_DATA;
                end
            end
            PH_DATA:
            begin
                result.valid          = 1'b1;
                result.kind           = KIND_DATA;
                result.data_byte      = rx_byte;
                result.byte_index     = state.bytes_seen[7:0];
                result.status         = ST_OK;
                state_next.running_sum = state.running_sum + rx_byte;
                state_next.bytes_seen  = seen_inc;
                if (seen_inc >= state.data_length)
                begin
                    state_next.phase = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                state_next.checksum_byte = rx_byte;
                state_next.phase         = PH_FOOTER;
            end
            default:
            begin
                result.valid     = 1'b1;
                result.kind      = KIND_STATUS;
                result.last      = 1'b1;
                state_next.phase = PH_START;
                priority if (rx_byte != BYTE_ETB && rx_byte != BYTE_ETX)
                begin
                    result.status = ST_FORMAT;
                end
                else if (check_sum != 8'd0)
                begin
                    result.status = ST_CHECKSUM;
                end
                else
                begin
                    result.status = ST_OK;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- test/cfr_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_frame_checker
// Watches both stream channels of the frame receiver, decodes every accepted
// input byte with its own frame decoder and compares each output transaction
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module cfr_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          bad_results,
    output int          results_awaited
);
    import cfr_pkg::*;

    typedef struct {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [1:0] status;
        logic [8:0] frame_length;
        logic       last;
    } frame_result_t;

    frame_result_t awaited_q[$];

    logic [2:0] phase;
    logic [7:0] start_byte;
    logic [8:0] decoded_len;
    logic [8:0] bytes_seen;
    logic [7:0] running_sum;
    logic [7:0] checksum_byte;

    initial
    begin
        bad_results     = 0;
        results_awaited = 0;
    end

    function automatic void post_status(input logic [1:0] st, input logic [8:0] flen);
        frame_result_t r;
        r.kind         = KIND_STATUS;
        r.data_byte    = 8'h00;
        r.byte_index   = 8'h00;
        r.status       = st;
        r.frame_length = flen;
        r.last         = 1'b1;
        awaited_q.push_back(r);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic [8:0] exp_len);
        logic [8:0]    dlen;
        logic [1:0]    st;
        frame_result_t r;
        case (phase)
            PH_START:
            begin
                start_byte = b;
                phase      = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                dlen        = (b == 8'h00) ? 9'd256 : {1'b0, b};
                decoded_len = dlen;
                if (start_byte != BYTE_STX || dlen > MAX_DATA_LEN)
                begin
                    phase = PH_START;
                    post_status(ST_FORMAT, dlen);
                end
                else if (exp_len != dlen)
                begin
                    phase = PH_START;
                    post_status(ST_LENGTH, dlen);
                end
                else
                begin
                    running_sum = b;
                    bytes_seen  = 9'd0;
                    phase       = PH_DATA;
                end
            end
            PH_DATA:
            begin
                r.kind         = KIND_DATA;
                r.data_byte    = b;
                r.byte_index   = bytes_seen[7:0];
                r.status       = ST_OK;
                r.frame_length = decoded_len;
                r.last         = 1'b0;
                awaited_q.push_back(r);
                running_sum = running_sum + b;
                bytes_seen  = bytes_seen + 9'd1;
                if (bytes_seen >= decoded_len)
                    phase = PH_CHECK;
            end
            PH_CHECK:
            begin
                checksum_byte = b;
                phase         = PH_FOOTER;
            end
            default:
            begin
                if (b != BYTE_ETB && b != BYTE_ETX)
                    st = ST_FORMAT;
                else if (8'(running_sum + checksum_byte) != 8'h00)
                    st = ST_CHECKSUM;
                else
                    st = ST_OK;
                phase = PH_START;
                post_status(st, decoded_len);
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            phase         = PH_START;
            start_byte    = 8'h00;
            decoded_len   = 9'd0;
            bytes_seen    = 9'd0;
            running_sum   = 8'h00;
            checksum_byte = 8'h00;
            awaited_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata[7:0], s_tdata[16:8]);
            if (m_tvalid && m_tready)
            begin
                if (awaited_q.size() == 0)
                begin
                    if (bad_results < 10)
                        $display("%0t: unexpected k=%0d b=%02h i=%0d s=%0d l=%0d t=%0d",
                                 $realtime, m_tuser, m_tdata[7:0], m_tdata[15:8],
                                 m_tdata[17:16], m_tdata[26:18], m_tlast);
                    bad_results++;
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (m_tuser !== want.kind || m_tdata[7:0] !== want.data_byte
                        || m_tdata[15:8] !== want.byte_index || m_tdata[17:16] !== want.status
                        || m_tdata[26:18] !== want.frame_length || m_tlast !== want.last)
                    begin
                        if (bad_results < 10)
                        begin
                            $display("%0t: expected k=%0d b=%02h i=%0d s=%0d l=%0d t=%0d",
                                     $realtime, want.kind, want.data_byte, want.byte_index,
                                     want.status, want.frame_length, want.last);
                            $display("%0t: actual   k=%0d b=%02h i=%0d s=%0d l=%0d t=%0d",
                                     $realtime, m_tuser, m_tdata[7:0], m_tdata[15:8],
                                     m_tdata[17:16], m_tdata[26:18], m_tlast);
                        end
                        bad_results++;
                    end
                end
            end
        end
        results_awaited = awaited_q.size();
    end

endmodule

// ----- test/checksummed_frame_receiver_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_unit_test
// Feeds the frame receiver with directed frames (good, bad start, length
// mismatch, bad footer, bad checksum), a long frame under a long output
// hold-off, and then random frames and noise under several idling patterns.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver_unit_test;
    import cfr_pkg::*;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZEROS  = 2;
    localparam int HOLD_CYCLES = 300;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int bad_results;
    int results_awaited;
    int items_sent    = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    always #4 clk = ~clk;

    checksummed_frame_receiver_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    cfr_frame_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .bad_results     (bad_results),
        .results_awaited (results_awaited)
    );

    // receiver: long hold-off on request, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic [8:0] exp_len);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, exp_len, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_frame(input logic [7:0] start_b, input logic [8:0] dlen,
                              input logic [8:0] exp_len, input bit good_sum,
                              input logic [7:0] footer, input int fill);
        logic [7:0] sum;
        logic [7:0] d;
        logic [7:0] chk;
        int         i;
        send_byte(start_b, 9'($urandom_range(511)));
        send_byte(dlen[7:0], exp_len);
        if (start_b == BYTE_STX && exp_len == dlen)
        begin
            sum = dlen[7:0];
            for (i = 0; i < dlen; i++)
            begin
                d = (fill == FILL_ONES) ? 8'hFF : (fill == FILL_ZEROS) ? 8'h00 : 8'($urandom);
                sum = sum + d;
                send_byte(d, 9'($urandom_range(511)));
            end
            chk = 8'h00 - sum;
            if (!good_sum)
                chk = chk + 8'($urandom_range(1, 255));
            send_byte(chk, 9'($urandom_range(511)));
            send_byte(footer, 9'($urandom_range(511)));
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        wait (results_awaited == 0);
        @(posedge clk);
    endtask

    task automatic run_phase(input int rx_pct, input int tx_pct, input int target);
        int         i;
        int         n;
        logic [8:0] dlen;
        logic [8:0] exp_len;
        logic [7:0] start_b;
        logic [7:0] footer;
        int         k;
        rx_stall_pct <= rx_pct;
        tx_idle_pct  = tx_pct;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 15)
            begin
                // line noise
                n = $urandom_range(1, 5);
                for (i = 0; i < n; i++)
                    send_byte(8'($urandom), 9'($urandom_range(511)));
            end
            else
            begin
                dlen    = ($urandom_range(49) == 0) ? 9'($urandom_range(100, 256))
                                                    : 9'($urandom_range(1, 12));
                start_b = ($urandom_range(19) == 0) ? 8'($urandom) : BYTE_STX;
                exp_len = ($urandom_range(9) == 0) ? 9'($urandom_range(511)) : dlen;
                k       = $urandom_range(19);
                footer  = (k == 0) ? 8'($urandom) : (k < 10) ? BYTE_ETX : BYTE_ETB;
                send_frame(start_b, dlen, exp_len, $urandom_range(9) != 0, footer, FILL_RANDOM);
            end
        end
        drain_results();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(BYTE_STX, 9'd1, 9'd1, 1'b1, BYTE_ETX, FILL_ONES);
        send_frame(8'h55, 9'd3, 9'd3, 1'b1, BYTE_ETX, FILL_RANDOM);
        send_frame(BYTE_STX, 9'd256, 9'd255, 1'b1, BYTE_ETX, FILL_RANDOM);
        send_frame(BYTE_STX, 9'd4, 9'd0, 1'b1, BYTE_ETX, FILL_RANDOM);
        send_frame(BYTE_STX, 9'd1, 9'd1, 1'b1, 8'h42, FILL_ZEROS);
        send_frame(BYTE_STX, 9'd1, 9'd1, 1'b0, BYTE_ETB, FILL_RANDOM);
        drain_results();

        // output held off while a long frame keeps coming
        hold_requests <= hold_requests + 1;
        send_frame(BYTE_STX, 9'd40, 9'd40, 1'b1, BYTE_ETX, FILL_RANDOM);
        drain_results();

        run_phase(0, 0, 340);
        rx_stall_pct <= 0;
        tx_idle_pct  = 0;
        send_frame(BYTE_STX, 9'd256, 9'd256, 1'b1, BYTE_ETB, FILL_RANDOM);
        run_phase(0, 70, 720);
        run_phase(70, 0, 1010);
        run_phase(35, 35, 1300);

        repeat (16) @(posedge clk);
        if (bad_results == 0 && results_awaited == 0)
            $display("checksummed_frame_receiver_unit_test: PASS");
        else
            $display("checksummed_frame_receiver_unit_test: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("checksummed_frame_receiver_unit_test: FAIL");
        $finish;
    end

endmodule
